/* sv/sgpf_pkg.sv */
// Package for the softened gravity pair force pipeline: payload structs,
// configuration register indexes, stage counts and datapath widths.
// No dependencies.
package sgpf_pkg;

  localparam int REG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int DM_W        = 31;              // scaled axis distance magnitude
  localparam int GM_W        = 64;              // gain * mass
  localparam int SQ_W        = 65;              // r^2 + eps^2
  localparam int DEN_W       = 97;              // (r^2 + eps^2) * r
  localparam int NUM_W       = 111;             // gain * mass * |d| * 2^16
  localparam int PRE_STAGES  = 4;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 32;
  localparam int MID_STAGES  = 2;
  localparam int LATENCY     = PRE_STAGES + SQRT_STAGES + MID_STAGES + DIV_STAGES + 1;
  localparam int KICKS       = 6;

  localparam logic [REG_W-1:0] LENGTH_SCALE_RST = 32'd65536;
  localparam logic [REG_W-1:0] FORCE_GAIN_RST   = 32'd65536;
  localparam logic [REG_W-1:0] SOFTENING_RST    = 32'd6554;
  localparam logic [REG_W-1:0] KICK_POS_MAX     = 32'h7FFF_FFFF;
  localparam logic [REG_W-1:0] KICK_NEG_MAG     = 32'h8000_0000;
  localparam logic [DM_W-1:0]  DM_MAX           = 31'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH_SCALE = 2'd0,
    CFG_FORCE_GAIN   = 2'd1,
    CFG_SOFTENING    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic        [31:0] first_mass;
    logic        [31:0] second_mass;
    logic               symmetric;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] first_kick_x;
    logic signed [31:0] first_kick_y;
    logic signed [31:0] first_kick_z;
    logic signed [31:0] second_kick_x;
    logic signed [31:0] second_kick_y;
    logic signed [31:0] second_kick_z;
    logic               coincident;
  } out_item_t;

  // Context carried alongside the square root stages
  typedef struct packed {
    logic [2:0][DM_W-1:0] dm;
    logic [2:0]           dneg;
    logic [GM_W-1:0]      gm1;
    logic [GM_W-1:0]      gm2;
    logic [SQ_W-1:0]      sq;
    logic                 sym;
  } sq_ctx_t;

endpackage

/* sv/sgpf_div.sv */
// Pipelined restoring divider for one kick: one quotient bit per stage,
// saturating magnitude and sign applied at the end. Depends on sgpf_pkg.
module sgpf_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [sgpf_pkg::NUM_W-1:0] num,
  input  logic [sgpf_pkg::DEN_W-1:0] den,
  input  logic                      neg,
  output logic [sgpf_pkg::REG_W-1:0] kick
);
  import sgpf_pkg::*;

  localparam int QW   = DIV_STAGES - 1;
  localparam int WIDE = DEN_W + QW;

  logic [NUM_W-1:0] rem_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];
  logic [QW-1:0]    q_r   [DIV_STAGES];
  logic             neg_r [DIV_STAGES];
  logic             sat_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int SH = DIV_STAGES - 1 - j;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QW-1:0]    q_in;
    logic             neg_in;
    logic             sat_in;
    logic [WIDE-1:0]  rem_w;
    logic [WIDE-1:0]  dsh;
    logic             ge;
    logic [QW-1:0]    q_nxt;
    logic             sat_nxt;

    assign rem_w = WIDE'(rem_in);
    assign dsh   = WIDE'(den_in) << SH;
    assign ge    = rem_w >= dsh;

    if (j == 0) begin : g_first
      assign rem_in  = num;
      assign den_in  = den;
      assign q_in    = '0;
      assign neg_in  = neg;
      assign sat_in  = 1'b0;
      // top quotient bit set means the result is at least 2^31: saturate
      assign sat_nxt = sat_in | ge;
      assign q_nxt   = q_in;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign den_in  = den_r[j-1];
      assign q_in    = q_r[j-1];
      assign neg_in  = neg_r[j-1];
      assign sat_in  = sat_r[j-1];
      assign sat_nxt = sat_in;
      always_comb begin
        q_nxt     = q_in;
        q_nxt[SH] = ge;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? NUM_W'(rem_w - dsh) : rem_in;
        den_r[j] <= den_in;
        q_r[j]   <= q_nxt;
        neg_r[j] <= neg_in;
        sat_r[j] <= sat_nxt;
      end
    end
  end

  logic [REG_W-1:0] mag;

  always_comb begin
    if (sat_r[DIV_STAGES-1]) begin
      mag = neg_r[DIV_STAGES-1] ? KICK_NEG_MAG : KICK_POS_MAX;
    end else begin
      mag = REG_W'(q_r[DIV_STAGES-1]);
    end
    kick = neg_r[DIV_STAGES-1] ? REG_W'(-mag) : mag;
  end

endmodule

/* sv/softened_gravity_pair_force.sv */
// Softened gravity pair force: fully pipelined, one transaction per cycle.
// Stages in order: 4 front stages, 32 square root stages (one root bit
// each), 2 product stages, 32 divider stages (one quotient bit each), 1 output.
// Throughput is one transaction per cycle; a stall on out_ready holds every stage.
// Synchronous active-low reset clears the valid pipe and restores the registers.
// Depends on sgpf_pkg and sgpf_div.
module softened_gravity_pair_force (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sgpf_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sgpf_pkg::out_item_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [sgpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgpf_pkg::REG_W-1:0]     cfg_data
);
  import sgpf_pkg::*;

  logic adv;
  logic [LATENCY-1:0] vld_r;

  logic [REG_W-1:0] scale_r;
  logic [REG_W-1:0] gain_r;
  logic [REG_W-1:0] soft_r;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= LENGTH_SCALE_RST;
      gain_r  <= FORCE_GAIN_RST;
      soft_r  <= SOFTENING_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LENGTH_SCALE: scale_r <= cfg_data;
        CFG_FORCE_GAIN:   gain_r  <= cfg_data;
        CFG_SOFTENING:    soft_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipe advances unless the output holds an untaken transaction
  assign adv      = !vld_r[LATENCY-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[LATENCY-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LATENCY-2:0], in_valid};
    end
  end

  // Stage 1: position differences
  logic [2:0][31:0] p1, p2;
  logic [2:0][31:0] am_nxt;
  logic [2:0]       neg_nxt;
  logic signed [32:0] diff [3];

  assign p1 = {in_data.first_z, in_data.first_y, in_data.first_x};
  assign p2 = {in_data.second_z, in_data.second_y, in_data.second_x};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a]    = $signed({p1[a][31], p1[a]}) - $signed({p2[a][31], p2[a]});
      neg_nxt[a] = diff[a][32];
      am_nxt[a]  = diff[a][32] ? 32'(-diff[a]) : diff[a][31:0];
    end
  end

  logic [2:0][31:0] s1_am_r;
  logic [2:0]       s1_neg_r;
  logic [31:0]      s1_m1_r, s1_m2_r;
  logic             s1_sym_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_am_r  <= am_nxt;
      s1_neg_r <= neg_nxt;
      s1_m1_r  <= in_data.first_mass;
      s1_m2_r  <= in_data.second_mass;
      s1_sym_r <= in_data.symmetric;
    end
  end

  // Stage 2: scale, gain * mass, softening squared
  logic [2:0][DM_W-1:0] dm_nxt;
  logic [63:0]          sprod [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sprod[a]  = 64'(s1_am_r[a]) * 64'(scale_r);
      dm_nxt[a] = (sprod[a][63:16] > 48'(DM_MAX)) ? DM_MAX : sprod[a][16+DM_W-1:16];
    end
  end

  logic [2:0][DM_W-1:0] s2_dm_r;
  logic [2:0]           s2_neg_r;
  logic [GM_W-1:0]      s2_gm1_r, s2_gm2_r, s2_eps2_r;
  logic                 s2_sym_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dm_r   <= dm_nxt;
      s2_neg_r  <= s1_neg_r;
      s2_gm1_r  <= 64'(gain_r) * 64'(s1_m1_r);
      s2_gm2_r  <= 64'(gain_r) * 64'(s1_m2_r);
      s2_eps2_r <= 64'(soft_r) * 64'(soft_r);
      s2_sym_r  <= s1_sym_r;
    end
  end

  // Stage 3: squares of the axis distances
  logic [2:0][2*DM_W-1:0] s3_dsq_r;
  logic [2:0][DM_W-1:0]   s3_dm_r;
  logic [2:0]             s3_neg_r;
  logic [GM_W-1:0]        s3_gm1_r, s3_gm2_r, s3_eps2_r;
  logic                   s3_sym_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        s3_dsq_r[a] <= (2*DM_W)'(s2_dm_r[a]) * (2*DM_W)'(s2_dm_r[a]);
      end
      s3_dm_r   <= s2_dm_r;
      s3_neg_r  <= s2_neg_r;
      s3_gm1_r  <= s2_gm1_r;
      s3_gm2_r  <= s2_gm2_r;
      s3_eps2_r <= s2_eps2_r;
      s3_sym_r  <= s2_sym_r;
    end
  end

  // Stage 4: r^2 and r^2 + eps^2, loaded into the root pipe
  logic [63:0] r2_nxt;
  sq_ctx_t     ctx_nxt;

  always_comb begin
    r2_nxt       = 64'(s3_dsq_r[0]) + 64'(s3_dsq_r[1]) + 64'(s3_dsq_r[2]);
    ctx_nxt.dm   = s3_dm_r;
    ctx_nxt.dneg = s3_neg_r;
    ctx_nxt.gm1  = s3_gm1_r;
    ctx_nxt.gm2  = s3_gm2_r;
    ctx_nxt.sq   = SQ_W'(r2_nxt) + SQ_W'(s3_eps2_r);
    ctx_nxt.sym  = s3_sym_r;
  end

  logic [63:0] sv_r   [SQRT_STAGES+1];
  logic [63:0] sres_r [SQRT_STAGES+1];
  sq_ctx_t     sctx_r [SQRT_STAGES+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_r[0]   <= r2_nxt;
      sres_r[0] <= '0;
      sctx_r[0] <= ctx_nxt;
    end
  end

  // Integer square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] trial;
    logic        take;

    assign trial = sres_r[k] + BIT;
    assign take  = sv_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sv_r[k+1]   <= take ? sv_r[k] - trial : sv_r[k];
        sres_r[k+1] <= take ? (sres_r[k] >> 1) + BIT : sres_r[k] >> 1;
        sctx_r[k+1] <= sctx_r[k];
      end
    end
  end

  // Stage E: partial products of denominator and numerators
  logic [31:0] root;
  sq_ctx_t     rctx;

  assign root = sres_r[SQRT_STAGES][31:0];
  assign rctx = sctx_r[SQRT_STAGES];

  logic [63:0]      e_den0_r, e_den1_r;
  logic             e_denh_r;
  logic [31:0]      e_root_r;
  logic [KICKS-1:0][DM_W+31:0] e_nlo_r, e_nhi_r;
  logic [KICKS-1:0] e_neg_r;
  logic             e_coin_r, e_sym_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_den0_r <= 64'(rctx.sq[31:0]) * 64'(root);
      e_den1_r <= 64'(rctx.sq[63:32]) * 64'(root);
      e_denh_r <= rctx.sq[64];
      e_root_r <= root;
      for (int a = 0; a < 3; a++) begin
        e_nlo_r[a]   <= (DM_W+32)'(rctx.gm2[31:0]) * (DM_W+32)'(rctx.dm[a]);
        e_nhi_r[a]   <= (DM_W+32)'(rctx.gm2[63:32]) * (DM_W+32)'(rctx.dm[a]);
        e_neg_r[a]   <= !rctx.dneg[a];
        e_nlo_r[a+3] <= (DM_W+32)'(rctx.gm1[31:0]) * (DM_W+32)'(rctx.dm[a]);
        e_nhi_r[a+3] <= (DM_W+32)'(rctx.gm1[63:32]) * (DM_W+32)'(rctx.dm[a]);
        e_neg_r[a+3] <= rctx.dneg[a];
      end
      e_coin_r <= (root == '0);
      e_sym_r  <= rctx.sym;
    end
  end

  // Stage F: sum partial products
  logic [DEN_W-1:0]            f_den_r;
  logic [KICKS-1:0][NUM_W-1:0] f_num_r;
  logic [KICKS-1:0]            f_neg_r;
  logic                        f_coin_r, f_sym_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_den_r <= DEN_W'(e_den0_r) + DEN_W'({e_den1_r, 32'b0})
               + (e_denh_r ? DEN_W'({e_root_r, 64'b0}) : '0);
      for (int n = 0; n < KICKS; n++) begin
        f_num_r[n] <= {(NUM_W-16)'(e_nlo_r[n]) + (NUM_W-16)'({e_nhi_r[n], 32'b0}), 16'b0};
      end
      f_neg_r  <= e_neg_r;
      f_coin_r <= e_coin_r;
      f_sym_r  <= e_sym_r;
    end
  end

  // Dividers, one per kick component
  logic [KICKS-1:0][REG_W-1:0] kick;

  for (genvar n = 0; n < KICKS; n++) begin : g_div
    sgpf_div u_div (
      .clk  (clk),
      .en   (adv),
      .num  (f_num_r[n]),
      .den  (f_den_r),
      .neg  (f_neg_r[n]),
      .kick (kick[n])
    );
  end

  // Carry the flags past the dividers
  logic [DIV_STAGES-1:0] dcoin_r, dsym_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dcoin_r <= {dcoin_r[DIV_STAGES-2:0], f_coin_r};
      dsym_r  <= {dsym_r[DIV_STAGES-2:0], f_sym_r};
    end
  end

  // Output register
  out_item_t out_r, out_nxt;
  logic      coin, keep2;

  always_comb begin
    coin  = dcoin_r[DIV_STAGES-1];
    keep2 = !coin && dsym_r[DIV_STAGES-1];
    out_nxt.first_kick_x  = coin  ? '0 : kick[0];
    out_nxt.first_kick_y  = coin  ? '0 : kick[1];
    out_nxt.first_kick_z  = coin  ? '0 : kick[2];
    out_nxt.second_kick_x = keep2 ? kick[3] : '0;
    out_nxt.second_kick_y = keep2 ? kick[4] : '0;
    out_nxt.second_kick_z = keep2 ? kick[5] : '0;
    out_nxt.coincident    = coin;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

/* sv/sgpf_checker.sv */
// Port-level checks for softened_gravity_pair_force, attached by bind.
// Depends on sgpf_pkg.
module sgpf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input sgpf_pkg::out_item_t            out_data
);
  import sgpf_pkg::*;

  // reset drains the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // no back pressure beyond the output side
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is taken");

  // coincident bodies give zero kicks
  a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.coincident |->
      out_data.first_kick_x == '0 && out_data.first_kick_y == '0 &&
      out_data.first_kick_z == '0 && out_data.second_kick_x == '0 &&
      out_data.second_kick_y == '0 && out_data.second_kick_z == '0)
    else $error("nonzero kick on coincident transaction");

endmodule

bind softened_gravity_pair_force sgpf_checker u_sgpf_checker (.*);
